// ===== sv/psl_pkg.sv =====
package psl_pkg;

    localparam int DEPTH = 256;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int POS_W = 9;
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int DATA_W = 32;

    typedef enum logic [2:0] {
        OP_READ         = 3'd0,
        OP_INSERT_AT    = 3'd1,
        OP_DELETE_AT    = 3'd2,
        OP_INSERT_FRONT = 3'd3,
        OP_INSERT_REAR  = 3'd4,
        OP_DELETE_FRONT = 3'd5,
        OP_DELETE_REAR  = 3'd6
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } t_status;

    // Shift command broadcast to every cell of the row.
    typedef struct packed {
        logic                     ins;
        logic                     del;
        logic [CMP_W-1:0]         at;
        logic signed [DATA_W-1:0] data;
    } t_shift;

endpackage

// ===== sv/psl_cell.sv =====
module psl_cell (
    input  logic                              i_clk,
    input  logic [psl_pkg::CMP_W-1:0]         i_index,
    input  psl_pkg::t_shift                   i_shift,
    input  logic [psl_pkg::CMP_W-1:0]         i_rd_pos,
    input  logic signed [psl_pkg::DATA_W-1:0] i_lower_elem,
    input  logic signed [psl_pkg::DATA_W-1:0] i_upper_elem,
    input  logic signed [psl_pkg::DATA_W-1:0] i_upper_rd,
    output logic signed [psl_pkg::DATA_W-1:0] o_elem,
    output logic signed [psl_pkg::DATA_W-1:0] o_rd
);
    import psl_pkg::*;

    logic signed [DATA_W-1:0] r_elem;
    logic signed [DATA_W-1:0] n_elem;
    logic signed [DATA_W-1:0] r_rd;
    logic signed [DATA_W-1:0] n_rd;

    always_comb begin
        n_elem = r_elem;
        if (i_shift.ins) begin
            if (i_index > i_shift.at) begin
                n_elem = i_lower_elem;
            end else if (i_index == i_shift.at) begin
                n_elem = i_shift.data;
            end
        end else if (i_shift.del) begin
            if (i_index >= i_shift.at) begin
                n_elem = i_upper_elem;
            end
        end
    end

    // The read word walks one cell toward the front in every cycle.
    assign n_rd = (i_index == i_rd_pos) ? r_elem : i_upper_rd;

    always_ff @(posedge i_clk) begin
        r_elem <= n_elem;
        r_rd   <= n_rd;
    end

    assign o_elem = r_elem;
    assign o_rd   = r_rd;

endmodule

// ===== sv/positional_shift_list_core.sv =====
// Channel   Handshake              Fields
// command   start and not busy     i_op, i_position, i_data_in
// result    o_valid, one cycle     o_data_out, o_status, o_count
//
// An insert, delete, rejected or ignored command passes from accept through
// S_EXEC to the registered result strobe; every cell shifts in parallel.
// A successful read stays in S_READ as its position counts down to zero;
// the read word walks the cell row one cell per cycle toward the front.
// Reset clears the element count and the control state; cell contents are
// not cleared. The result cannot be stalled; busy is low in the strobe cycle.
module positional_shift_list_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [2:0]                        i_op,
    input  logic [psl_pkg::POS_W-1:0]         i_position,
    input  logic signed [psl_pkg::DATA_W-1:0] i_data_in,
    output logic                              o_valid,
    output logic signed [psl_pkg::DATA_W-1:0] o_data_out,
    output logic [1:0]                        o_status,
    output logic [psl_pkg::POS_W-1:0]         o_count
);
    import psl_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_READ = 3'b100
    } t_state;

    t_state                   r_state;
    t_state                   n_state;
    logic [2:0]               r_op;
    logic [CMP_W-1:0]         r_pos;
    logic signed [DATA_W-1:0] r_data;
    logic [CNT_W-1:0]         r_count;
    logic [CNT_W-1:0]         n_count;
    logic [CMP_W-1:0]         r_rd_cnt;
    logic [CMP_W-1:0]         n_rd_cnt;
    logic                     r_valid;
    logic                     n_valid;
    logic signed [DATA_W-1:0] r_data_out;
    logic signed [DATA_W-1:0] n_data_out;
    logic [1:0]               r_status;
    logic [1:0]               n_status;

    t_shift                   w_shift;
    t_status                  w_status;
    logic [CMP_W-1:0]         w_count;
    logic                     w_read_ok;
    logic                     w_ins_ok;
    logic                     w_del_ok;
    logic [CMP_W-1:0]         w_at;

    logic signed [DATA_W-1:0] w_elem [DEPTH];
    logic signed [DATA_W-1:0] w_rd   [DEPTH];

    assign w_count = CMP_W'(r_count);

    always_comb begin
        w_status  = ST_OK;
        w_read_ok = 1'b0;
        w_ins_ok  = 1'b0;
        w_del_ok  = 1'b0;
        w_at      = '0;
        case (r_op)
            OP_READ: begin
                if (w_count == '0) begin
                    w_status = ST_EMPTY;
                end else if (r_pos >= w_count) begin
                    w_status = ST_RANGE;
                end else begin
                    w_read_ok = 1'b1;
                end
            end
            OP_INSERT_AT, OP_INSERT_FRONT, OP_INSERT_REAR: begin
                if (w_count == CMP_W'(DEPTH)) begin
                    w_status = ST_FULL;
                end else if (r_op == OP_INSERT_AT && r_pos > w_count) begin
                    w_status = ST_RANGE;
                end else begin
                    w_ins_ok = 1'b1;
                    if (r_op == OP_INSERT_AT) begin
                        w_at = r_pos;
                    end else if (r_op == OP_INSERT_REAR) begin
                        w_at = w_count;
                    end
                end
            end
            OP_DELETE_AT, OP_DELETE_FRONT, OP_DELETE_REAR: begin
                if (w_count == '0) begin
                    w_status = ST_EMPTY;
                end else if (r_op == OP_DELETE_AT && r_pos >= w_count) begin
                    w_status = ST_RANGE;
                end else begin
                    w_del_ok = 1'b1;
                    if (r_op == OP_DELETE_AT) begin
                        w_at = r_pos;
                    end else if (r_op == OP_DELETE_REAR) begin
                        w_at = w_count - CMP_W'(1);
                    end
                end
            end
            default: begin
                w_status = ST_OK;
            end
        endcase
    end

    always_comb begin
        w_shift.ins  = (r_state == S_EXEC) && w_ins_ok;
        w_shift.del  = (r_state == S_EXEC) && w_del_ok;
        w_shift.at   = w_at;
        w_shift.data = r_data;
    end

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            logic signed [DATA_W-1:0] w_lower;
            logic signed [DATA_W-1:0] w_upper;
            logic signed [DATA_W-1:0] w_upper_rd;
            if (gi == 0) begin : g_first
                assign w_lower = '0;
            end else begin : g_mid_lo
                assign w_lower = w_elem[gi-1];
            end
            if (gi == DEPTH - 1) begin : g_last
                assign w_upper    = '0;
                assign w_upper_rd = '0;
            end else begin : g_mid_hi
                assign w_upper    = w_elem[gi+1];
                assign w_upper_rd = w_rd[gi+1];
            end
            psl_cell u_cell (
                .i_clk        (i_clk),
                .i_index      (CMP_W'(gi)),
                .i_shift      (w_shift),
                .i_rd_pos     (r_pos),
                .i_lower_elem (w_lower),
                .i_upper_elem (w_upper),
                .i_upper_rd   (w_upper_rd),
                .o_elem       (w_elem[gi]),
                .o_rd         (w_rd[gi])
            );
        end
    endgenerate

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_rd_cnt   = r_rd_cnt;
        n_valid    = 1'b0;
        n_data_out = '0;
        n_status   = r_status;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_read_ok) begin
                    n_state  = S_READ;
                    n_rd_cnt = r_pos;
                end else begin
                    n_state  = S_IDLE;
                    n_valid  = 1'b1;
                    n_status = w_status;
                    if (w_ins_ok) begin
                        n_count = r_count + CNT_W'(1);
                    end else if (w_del_ok) begin
                        n_count = r_count - CNT_W'(1);
                    end
                end
            end
            S_READ: begin
                if (r_rd_cnt == '0) begin
                    n_state    = S_IDLE;
                    n_valid    = 1'b1;
                    n_status   = ST_OK;
                    n_data_out = w_rd[0];
                end else begin
                    n_rd_cnt = r_rd_cnt - CMP_W'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && start) begin
            r_op   <= i_op;
            r_pos  <= CMP_W'(i_position);
            r_data <= i_data_in;
        end
        r_rd_cnt   <= n_rd_cnt;
        r_data_out <= n_data_out;
        r_status   <= n_status;
    end

    assign busy       = (r_state != S_IDLE);
    assign o_valid    = r_valid;
    assign o_data_out = r_data_out;
    assign o_status   = r_status;
    assign o_count    = POS_W'(r_count);

endmodule

// ===== sv/psl_checker.sv =====
module psl_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_start,
    input logic                              i_busy,
    input logic                              i_valid,
    input logic signed [psl_pkg::DATA_W-1:0] i_data_out,
    input logic [1:0]                        i_status,
    input logic [psl_pkg::POS_W-1:0]         i_count
);
    import psl_pkg::*;

    // A new transaction keeps the block busy until its result is shown.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !i_busy) |=> i_busy)
        else $error("block not busy after an accepted transaction");

    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> (!i_busy && $past(i_busy)))
        else $error("result strobe without a finished transaction");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_status == ST_EMPTY) |-> (i_count == '0))
        else $error("empty status with a nonzero count");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_status == ST_FULL) |-> (i_count == POS_W'(DEPTH)))
        else $error("full status with a count below the depth");

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_status != ST_OK) |-> (i_data_out == '0))
        else $error("rejected transaction returned nonzero data");

endmodule

bind positional_shift_list_core psl_checker u_psl_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_start    (start),
    .i_busy     (busy),
    .i_valid    (o_valid),
    .i_data_out (o_data_out),
    .i_status   (o_status),
    .i_count    (o_count)
);
